// ===== src/tprgba_pkg.sv =====
// Shared widths, codes and types for the texture pixel to RGBA converter.
package tprgba_pkg;

  // Configuration register widths and indexes
  localparam int PIXEL_FORMAT_W = 6;
  localparam int PALETTE_SIZE_W = 9;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SIZE = 1'd1;

  localparam logic [PIXEL_FORMAT_W-1:0] PIXEL_FORMAT_RST = 6'd8;
  localparam logic [PALETTE_SIZE_W-1:0] PALETTE_SIZE_RST = 9'd0;

  // Source format codes
  localparam logic [PIXEL_FORMAT_W-1:0] FMT_PAL8      = 6'd3;
  localparam logic [PIXEL_FORMAT_W-1:0] FMT_PAL8_A8   = 6'd4;
  localparam logic [PIXEL_FORMAT_W-1:0] FMT_ARGB4444  = 6'd6;
  localparam logic [PIXEL_FORMAT_W-1:0] FMT_RGB888    = 6'd7;
  localparam logic [PIXEL_FORMAT_W-1:0] FMT_BGRA8888  = 6'd8;

  // Result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;

  // Input item: func in tuser, entry_index and raw_word in tdata
  localparam int ENTRY_W     = 8;
  localparam int RAW_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  localparam logic FUNC_PAL_WRITE = 1'b0;
  localparam logic FUNC_CONVERT   = 1'b1;

  // Palette entry: R in 23:16, G in 15:8, B in 7:0
  localparam int PAL_ENTRY_W       = 24;
  localparam int PALETTE_DEPTH_DEF = 256;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

endpackage

// ===== src/texture_pixel_to_rgba_converter.sv =====
// Top level: palette and packed pixel to RGBA8888 converter.
//
// Converts one source pixel per clock, while not stalled, to RGBA8888 in the
// mode chosen by the pixel_format register (3 palette index, 4 palette index
// plus alpha, 6 packed 4444, 7 RGB888, 8 BGRA8888) and stores palette entries
// from palette-write beats, which give no result. The block takes a beat every
// cycle unless both stages are full and the output is stalled. A conversion
// beat's palette read is registered in the read stage, and its result then in
// the output register. A stage that is free keeps taking beats while a result
// waits at the output. Palette writes take effect for the next beat, so a
// write followed at once by a read of the same entry returns the new colour.
// Palette entries hold no defined value until written; an index at or above
// palette_size or PALETTE_DEPTH returns status 1 and zero colour, an unknown
// format returns status 2 and zero colour.
module texture_pixel_to_rgba_converter #(
  parameter int PALETTE_DEPTH = tprgba_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tprgba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tprgba_pkg::CFG_DATA_W-1:0]     cfg_data,
  // source pixel stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tprgba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // entry_index[7:0], raw_word[39:8]
  input  logic                                  s_axis_tuser,  // func[0]
  // RGBA result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [tprgba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [tprgba_pkg::STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

  import tprgba_pkg::*;

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [PALETTE_SIZE_W-1:0] DEPTH_LIM = PALETTE_SIZE_W'(PALETTE_DEPTH);

  // configuration registers
  logic [PIXEL_FORMAT_W-1:0] pixel_format;
  logic [PALETTE_SIZE_W-1:0] palette_size;

  // palette store
  logic [PAL_ENTRY_W-1:0] palette_mem [0:PALETTE_DEPTH-1];

  // read stage
  logic                   s1_valid;
  logic [RAW_W-1:0]       s1_raw;
  logic [PAL_ENTRY_W-1:0] s1_entry;

  // output register
  logic                   out_valid;
  rgba_t                  out_rgba;
  logic [STATUS_W-1:0]    out_status;

  // conversion result
  rgba_t                  rgba_next;
  logic [STATUS_W-1:0]    status_next;

  logic                   out_en;
  logic                   s_accept;
  logic                   in_func;
  logic [ENTRY_W-1:0]     in_entry;
  logic [RAW_W-1:0]       in_raw;
  logic                   pal_wr_ok;
  logic [7:0]             pix_idx;
  logic                   idx_bad;

  assign in_entry = s_axis_tdata[ENTRY_W-1:0];
  assign in_raw   = s_axis_tdata[ENTRY_W +: RAW_W];
  assign in_func  = s_axis_tuser;

  // handshake: the output register frees when taken, the read stage when it moves on
  assign out_en        = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_en;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= PIXEL_FORMAT_RST;
      palette_size <= PALETTE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[PIXEL_FORMAT_W-1:0];
        REG_PALETTE_SIZE: palette_size <= cfg_data[PALETTE_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // palette write, drop entries beyond the store
  assign pal_wr_ok = ({1'b0, in_entry} < DEPTH_LIM);

  always_ff @(posedge clk) begin
    if (s_accept && in_func == FUNC_PAL_WRITE && pal_wr_ok) begin
      palette_mem[in_entry[ADDR_W-1:0]] <= {in_raw[23:16], in_raw[15:8], in_raw[7:0]};
    end
  end

  // registered palette read for conversion beats
  always_ff @(posedge clk) begin
    if (s_accept && in_func == FUNC_CONVERT) begin
      s1_entry <= palette_mem[in_raw[ADDR_W-1:0]];
      s1_raw   <= in_raw;
    end
  end

  // read stage occupancy: only conversion beats carry on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= (in_func == FUNC_CONVERT);
    end else if (out_en) begin
      s1_valid <= 1'b0;
    end
  end

  // range check on the palette index
  assign pix_idx = s1_raw[7:0];
  assign idx_bad = ({1'b0, pix_idx} >= palette_size) || ({1'b0, pix_idx} >= DEPTH_LIM);

  // convert one pixel
  always_comb begin
    rgba_next   = '0;
    status_next = ST_OK;
    case (pixel_format)
      FMT_PAL8, FMT_PAL8_A8: begin
        if (idx_bad) begin
          status_next = ST_RANGE;
        end else begin
          rgba_next.red   = s1_entry[23:16];
          rgba_next.green = s1_entry[15:8];
          rgba_next.blue  = s1_entry[7:0];
          rgba_next.alpha = (pixel_format == FMT_PAL8) ? 8'hFF : s1_raw[15:8];
        end
      end
      FMT_ARGB4444: begin
        rgba_next.red   = {s1_raw[11:8], 4'h0};
        rgba_next.green = {s1_raw[7:4], 4'h0};
        rgba_next.blue  = {s1_raw[3:0], 4'h0};
        rgba_next.alpha = {s1_raw[15:12], 4'h0};
      end
      FMT_RGB888: begin
        rgba_next.red   = s1_raw[7:0];
        rgba_next.green = s1_raw[15:8];
        rgba_next.blue  = s1_raw[23:16];
        rgba_next.alpha = 8'hFF;
      end
      FMT_BGRA8888: begin
        rgba_next.red   = s1_raw[23:16];
        rgba_next.green = s1_raw[15:8];
        rgba_next.blue  = s1_raw[7:0];
        rgba_next.alpha = s1_raw[31:24];
      end
      default: begin
        status_next = ST_UNSUPPORTED;
      end
    endcase
  end

  // output register: load when free, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      out_rgba   <= rgba_next;
      out_status <= status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_rgba;
  assign m_axis_tuser  = out_status;

  // a palette write never enters the read stage
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_accept && in_func == FUNC_PAL_WRITE) |=> (s1_valid == $past(s1_valid && !out_en)))
    else $error("palette write produced a result");

  // an error result carries zero colour
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_RANGE || m_axis_tuser == ST_UNSUPPORTED))
      |-> (m_axis_tdata == '0))
    else $error("error result with non-zero colour");

  // status code stays within its defined set
  a_status_known: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_RANGE ||
                       m_axis_tuser == ST_UNSUPPORTED))
    else $error("undefined status code");

  // both stages full and stalled: no beat may be taken
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("beat taken with pipeline full");

  // a waiting result does not block a free read stage
  a_accept_while_waiting: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid) |-> s_axis_tready)
    else $error("free read stage refused a beat");

endmodule
